@@ sv/ffra_pkg.sv @@
// Shared types, constants and field layout for the first-fit region allocator.
package ffra_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam logic [31:0] DefaultWindowBytes = 32'd4194304;
  localparam logic [31:0] DefaultWindowBase  = 32'h8F00_0000;
  localparam logic [32:0] PageLowBits = 33'd4095;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegWindowBytes = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWindowBase  = 1'd1;

  localparam logic CmdAlloc   = 1'b0;
  localparam logic CmdRelease = 1'b1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoFit   = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StScan,
    StDrain,
    StPassEnd,
    StFinish
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic rd;
    logic finish;
  } ffra_cmd_t;

  typedef struct packed {
    logic is_release;
    logic rd_last;
    logic moved;
    logic out_free;
  } ffra_sts_t;

  function automatic logic [32:0] page_round(input logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, v} + PageLowBits;
    return s & ~PageLowBits;
  endfunction

endpackage

@@ sv/ffra_ctrl.sv @@
// Controller state machine sequencing drop, table sweeps and result delivery.
module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ffra_sts_t sts_i,
  output ffra_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StStart;
      end
      StStart: begin
        state_d = sts_i.is_release ? StFinish : StScan;
      end
      StScan: begin
        if (sts_i.rd_last) state_d = StDrain;
      end
      StDrain: begin
        state_d = StPassEnd;
      end
      StPassEnd: begin
        state_d = sts_i.moved ? StScan : StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StStart: begin
        cmd_o.pass_start = !sts_i.is_release;
      end
      StScan: begin
        cmd_o.rd = 1'b1;
      end
      StPassEnd: begin
        cmd_o.pass_start = sts_i.moved;
      end
      StFinish: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == StIdle)
    else $error("finish did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("second word accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> state_q == StScan && !in_ready_o)
    else $error("table read outside a sweep");

endmodule

@@ sv/ffra_dp.sv @@
// Datapath: region table, first-fit search position, config and output registers.
module ffra_dp
  import ffra_pkg::*;
#(
  parameter int unsigned Entries = DefaultEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  input  ffra_cmd_t           cmd_i,
  output ffra_sts_t           sts_o
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  logic [31:0] win_bytes_q, win_base_q;
  logic [Entries-1:0] valid_q;
  logic [7:0] owner_q [Entries];
  logic [64:0] mem [Entries];
  logic [64:0] rd_data_q;

  logic        release_q;
  logic [7:0]  req_owner_q;
  logic [32:0] size_q;
  logic [33:0] pos_q;
  logic        moved_q;
  logic [IdxW-1:0] rd_idx_q, chk_idx_q, free_idx_q;
  logic        chk_q, free_found_q;
  logic        out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [33:0] ent_end;
  logic [34:0] pos_top, fit_top;
  logic        blocks, fits;
  logic [31:0] res_off, res_bytes, res_phys;
  logic [1:0]  res_status;

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_bytes_q <= DefaultWindowBytes;
      win_base_q  <= DefaultWindowBase;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWindowBytes: win_bytes_q <= cfg_data_i;
        RegWindowBase:  win_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Start and length memory, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && !release_q && res_status == StatusOk) begin
      mem[free_idx_q] <= {size_q, pos_q[31:0]};
    end
    rd_data_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && !release_q && res_status == StatusOk) begin
      owner_q[free_idx_q] <= req_owner_q;
    end
  end

  assign ent_end = {2'b0, rd_data_q[31:0]} + {1'b0, rd_data_q[64:32]};
  assign pos_top = {1'b0, pos_q} + {2'b0, size_q};
  assign blocks  = chk_q && valid_q[chk_idx_q]
                   && ({3'b0, rd_data_q[31:0]} < pos_top) && (ent_end > pos_q);
  assign fit_top = pos_top;
  assign fits    = fit_top <= {3'b0, win_bytes_q};

  always_comb begin
    res_status = StatusOk;
    res_off    = pos_q[31:0];
    res_bytes  = size_q[31:0];
    res_phys   = win_base_q + pos_q[31:0];
    if (release_q) begin
      res_status = StatusOk;
    end else if (!fits) begin
      res_status = StatusNoFit;
    end else if (!free_found_q) begin
      res_status = StatusFull;
    end
    if (release_q || res_status != StatusOk) begin
      res_off   = '0;
      res_bytes = '0;
      res_phys  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      release_q    <= 1'b0;
      req_owner_q  <= '0;
      size_q       <= '0;
      pos_q        <= '0;
      moved_q      <= 1'b0;
      rd_idx_q     <= '0;
      chk_idx_q    <= '0;
      chk_q        <= 1'b0;
      free_idx_q   <= '0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      chk_q     <= cmd_i.rd;
      chk_idx_q <= rd_idx_q;
      if (cmd_i.load) begin
        release_q    <= in_data_i[0] == CmdRelease;
        req_owner_q  <= in_data_i[8:1];
        size_q       <= page_round(in_data_i[40:9]);
        pos_q        <= {1'b0, page_round(in_data_i[72:41])};
        free_found_q <= 1'b0;
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i] && owner_q[i] == in_data_i[8:1]) valid_q[i] <= 1'b0;
        end
      end
      if (cmd_i.pass_start) begin
        rd_idx_q <= '0;
        moved_q  <= 1'b0;
      end else if (cmd_i.rd && rd_idx_q != LastIdx) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (chk_q && !valid_q[chk_idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= chk_idx_q;
      end
      if (blocks) begin
        pos_q   <= ent_end;
        moved_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {6'b0, res_phys, res_bytes, res_off, res_status};
        if (!release_q && res_status == StatusOk) valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.is_release = release_q;
  assign sts_o.rd_last    = rd_idx_q == LastIdx;
  assign sts_o.moved      = moved_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load |=> pos_q >= $past(pos_q))
    else $error("search position moved backward");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && !release_q && res_status == StatusOk |=> valid_q[$past(free_idx_q)])
    else $error("granted entry not marked valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    moved_q && !$past(moved_q) |-> $past(chk_q))
    else $error("position moved without a table read");

endmodule

@@ sv/first_fit_region_allocator_top.sv @@
// Top level of the first-fit region allocator: controller plus datapath.
//
// The block keeps a table of up to ENTRIES owner-tagged regions inside a
// memory window and serves one allocate or release word at a time. On
// acceptance, any region the owner holds is dropped in that same cycle. An
// allocate then sweeps the table one entry per cycle from a registered
// memory read; whenever an entry overlaps the candidate region, the candidate
// moves to that entry's end, and the sweep repeats until a full sweep makes
// no move, so an allocate takes at least one sweep and at most ENTRIES + 1;
// a release makes no sweep. The result waits in an output register, and
// the next word is taken as soon as the result has been loaded there. The
// two config registers may be written whenever the block is idle.
module first_fit_region_allocator_top
  import ffra_pkg::*;
#(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0: command, owner_id, request_bytes, min_offset.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Fields from bit 0: status, granted_offset, granted_bytes, phys_addr.
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ffra_cmd_t cmd;
  ffra_sts_t sts;

  ffra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffra_dp #(
    .Entries (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ sim/first_fit_region_allocator_top_tb.sv @@
// Self-checking testbench for the first-fit region allocator top level.
`timescale 1ns / 1ps

module first_fit_region_allocator_top_tb;
  import ffra_pkg::*;

  localparam int unsigned NumSlots = DefaultEntries;
  localparam int unsigned CycleLimit = 2000000;

  // One request word as it travels on the slave-side stream.
  typedef struct packed {
    logic [31:0] min_offset;
    logic [31:0] request_bytes;
    logic [7:0]  owner_id;
    logic        command;
  } request_t;

  // One grant word as it travels on the master-side stream.
  typedef struct packed {
    logic [31:0] phys_addr;
    logic [31:0] granted_bytes;
    logic [31:0] granted_offset;
    logic [1:0]  status;
  } grant_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  first_fit_region_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Shadow of the region table and of the window registers.
  logic        slot_used  [NumSlots];
  logic [7:0]  slot_owner [NumSlots];
  logic [31:0] slot_start [NumSlots];
  logic [32:0] slot_len   [NumSlots];
  logic [31:0] win_bytes;
  logic [31:0] win_base;

  request_t pending_requests[$];
  grant_t   expected_grants[$];
  int       fail_count;
  int       cycle_count;
  int       send_gap;
  int       recv_gap;

  function automatic logic [63:0] round_to_page(input logic [31:0] v);
    return ({32'd0, v} + 64'd4095) & ~64'd4095;
  endfunction

  // Applies one request to the shadow table and returns the grant it causes.
  // The walk revisits the table until a full sweep moves the candidate no
  // more; this lands on the same first-fit gap as an ordered walk.
  function automatic grant_t allocate_region(input request_t req);
    grant_t      g;
    logic [63:0] size;
    logic [63:0] pos;
    logic [63:0] s;
    logic [63:0] e;
    int          free_slot;
    logic        moved;
    g = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_used[i] && slot_owner[i] == req.owner_id) slot_used[i] = 1'b0;
    end
    if (req.command == CmdRelease) return g;
    size = round_to_page(req.request_bytes);
    pos  = round_to_page(req.min_offset);
    free_slot = -1;
    for (int i = 0; i < NumSlots; i++) begin
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    // A region that ends at or before pos or starts at or after pos + size leaves
    // the candidate alone; any overlap pushes it to that region's end.
    do begin
      moved = 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        if (slot_used[i]) begin
          s = {32'd0, slot_start[i]};
          e = s + {31'd0, slot_len[i]};
          if (pos + size > s && e > pos) begin
            pos = e;
            moved = 1'b1;
          end
        end
      end
    end while (moved);
    if (pos + size > {32'd0, win_bytes}) begin
      g.status = StatusNoFit;
      return g;
    end
    if (free_slot < 0) begin
      g.status = StatusFull;
      return g;
    end
    slot_used[free_slot]  = 1'b1;
    slot_owner[free_slot] = req.owner_id;
    slot_start[free_slot] = pos[31:0];
    slot_len[free_slot]   = size[32:0];
    g.status         = StatusOk;
    g.granted_offset = pos[31:0];
    g.granted_bytes  = size[31:0];
    g.phys_addr      = win_base + pos[31:0];
    return g;
  endfunction

  // Driver: presents queued words with random gaps; the expected grant is
  // computed at the edge that accepts the word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      send_gap        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_grants = {expected_grants,
                           allocate_region(request_t'(s_axis_tdata_i[72:0]))};
        void'(pending_requests.pop_front());
        send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (pending_requests.size() > 0 && $urandom_range(0, 3) == 0) begin
          s_axis_tdata_i <= {7'd0, pending_requests[0]};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end else if (!s_axis_tvalid_i) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {7'd0, pending_requests[0]};
        end
      end
    end
  end

  // Monitor: random backpressure, field-by-field comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t got;
    grant_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_gap        <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = grant_t'(m_axis_tdata_o[97:0]);
        if (expected_grants.size() == 0) begin
          $error("unexpected grant word %h", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.granted_offset !== want.granted_offset) begin
            $error("granted_offset: expected %h, got %h",
                   want.granted_offset, got.granted_offset);
            fail_count++;
          end
          if (got.granted_bytes !== want.granted_bytes) begin
            $error("granted_bytes: expected %h, got %h",
                   want.granted_bytes, got.granted_bytes);
            fail_count++;
          end
          if (got.phys_addr !== want.phys_addr) begin
            $error("phys_addr: expected %h, got %h", want.phys_addr, got.phys_addr);
            fail_count++;
          end
        end
        recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL first_fit_region_allocator_top");
      $finish;
    end
  end

  task automatic queue_request(input logic cmd, input logic [7:0] owner,
                               input logic [31:0] bytes_req,
                               input logic [31:0] min_off);
    request_t r;
    r.command       = cmd;
    r.owner_id      = owner;
    r.request_bytes = bytes_req;
    r.min_offset    = min_off;
    pending_requests = {pending_requests, r};
  endtask

  // Writes one window register; only called while the block is idle.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWindowBytes) win_bytes = val;
    else win_base = val;
  endtask

  // Waits until every queued word has been answered, then lets the block settle.
  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_grants.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly small sizes, often not page-aligned, so the table fills and fragments; now and
  // then a full-range value to reach the overflow paths.
  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'd0;
      2:       return $urandom_range(0, 16) * 4096;
      default: return $urandom_range(1, 120000);
    endcase
  endfunction

  task automatic random_phase(input int count, input logic [31:0] win);
    for (int n = 0; n < count; n++) begin
      logic [31:0] off;
      off = ($urandom_range(0, 3) == 0) ? $urandom() :
            $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(0, win >> 1);
      queue_request($urandom_range(0, 4) == 0 ? CmdRelease : CmdAlloc,
                    $urandom_range(0, 7) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 23)),
                    pick_size(), off);
    end
  endtask

  initial begin
    fail_count      = 0;
    cycle_count     = 0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    win_bytes       = DefaultWindowBytes;
    win_base        = DefaultWindowBase;
    for (int i = 0; i < NumSlots; i++) slot_used[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset window: extremes, zero size, owner drop,
    // release of an idle owner, no-fit, and a table-full run.
    queue_request(CmdAlloc, 8'd0, 32'd0, 32'd0);
    queue_request(CmdAlloc, 8'd255, 32'd1, 32'd0);
    queue_request(CmdAlloc, 8'd1, 32'd4096, 32'd4095);
    queue_request(CmdAlloc, 8'd2, 32'hFFFF_FFFF, 32'd0);
    queue_request(CmdAlloc, 8'd3, 32'd4096, 32'hFFFF_FFFF);
    queue_request(CmdAlloc, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CmdRelease, 8'd77, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CmdRelease, 8'd255, 32'd0, 32'd0);
    for (int k = 0; k < 17; k++) queue_request(CmdAlloc, 8'(10 + k), 32'd8192, 32'd0);
    wait_drained();

    // Tiny window at address wrap, the largest window, an empty window, then a 1 MiB one.
    write_register(RegWindowBytes, 32'd65536);
    write_register(RegWindowBase, 32'hFFFF_F000);
    random_phase(150, 32'd65536);
    wait_drained();
    write_register(RegWindowBytes, 32'hFFFF_FFFF);
    write_register(RegWindowBase, 32'h0);
    queue_request(CmdAlloc, 8'd200, 32'hFFFF_F000, 32'd0);
    queue_request(CmdAlloc, 8'd201, 32'd1, 32'd0);
    random_phase(150, 32'hFFFF_FFFF);
    wait_drained();
    write_register(RegWindowBytes, 32'd0);
    write_register(RegWindowBase, 32'hFFFF_FFFF);
    random_phase(40, 32'd0);
    wait_drained();
    write_register(RegWindowBytes, 32'd1048576);
    write_register(RegWindowBase, $urandom());
    random_phase(250, 32'd1048576);
    wait_drained();
    repeat (50) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS first_fit_region_allocator_top");
    end else begin
      $display("FAIL first_fit_region_allocator_top");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ffra_pkg.sv
sv/ffra_ctrl.sv
sv/ffra_dp.sv
sv/first_fit_region_allocator_top.sv
sim/first_fit_region_allocator_top_tb.sv
